@@ rtl/core/range_image_to_xyz_points_unit_macros.svh @@
// assertion macros for the range image to point unit
`ifndef RANGE_IMAGE_TO_XYZ_POINTS_UNIT_MACROS_SVH
`define RANGE_IMAGE_TO_XYZ_POINTS_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define RIX_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RIX_ASSERT_R(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RIX_ASSERT(label, clk, rst, prop, msg)
`define RIX_ASSERT_R(label, clk, prop, msg)
`endif
`endif

@@ rtl/core/rix_pkg.sv @@
// shared types, constants and tables of the range image to point unit
`default_nettype none
package rix_pkg;
  localparam int unsigned ITER = 24;
  localparam int unsigned ROM_DEPTH = 32;
  localparam int unsigned VW = 44;
  localparam logic signed [15:0] RANGE_OFFSET = 16'sd4046;
  localparam logic [31:0] INV_PI = 32'd1367130551;
  localparam logic [23:0] INV_GAIN = 24'd10188014;
  localparam logic [1:0] REG_AZ = 2'd0;
  localparam logic [1:0] REG_ALT = 2'd1;
  localparam logic [1:0] REG_INT = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [15:0] inten;
    logic [23:0] az;
  } side_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [33:0]   z;
  } vec_t;

  function automatic logic signed [15:0] beam_rom(input logic [4:0] i);
    logic signed [15:0] r;
    case (i)
      5'd0: r = -16'sd9500;  5'd1: r = -16'sd9199;  5'd2: r = -16'sd8897;
      5'd3: r = -16'sd8595;  5'd4: r = -16'sd8294;  5'd5: r = -16'sd7992;
      5'd6: r = -16'sd7690;  5'd7: r = -16'sd7389;  5'd8: r = -16'sd7088;
      5'd9: r = -16'sd6786;  5'd10: r = -16'sd6484; 5'd11: r = -16'sd6183;
      5'd12: r = -16'sd5881; 5'd13: r = -16'sd5580; 5'd14: r = -16'sd5278;
      5'd15: r = -16'sd4976; 5'd16: r = -16'sd4675; 5'd17: r = -16'sd4373;
      5'd18: r = -16'sd4071; 5'd19: r = -16'sd3770; 5'd20: r = -16'sd3468;
      5'd21: r = -16'sd3167; 5'd22: r = -16'sd2865; 5'd23: r = -16'sd2563;
      5'd24: r = -16'sd2262; 5'd25: r = -16'sd1960; 5'd26: r = -16'sd1659;
      5'd27: r = -16'sd1357; 5'd28: r = -16'sd1056; 5'd29: r = -16'sd754;
      5'd30: r = -16'sd452;  default: r = -16'sd151;
    endcase
    return r;
  endfunction

  function automatic logic [29:0] turn_atan(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0: r = 30'd536870912; 5'd1: r = 30'd316933406; 5'd2: r = 30'd167458907;
      5'd3: r = 30'd85004756;  5'd4: r = 30'd42667331;  5'd5: r = 30'd21354465;
      5'd6: r = 30'd10679838;  5'd7: r = 30'd5340245;   5'd8: r = 30'd2670163;
      5'd9: r = 30'd1335087;   5'd10: r = 30'd667544;   5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;   5'd13: r = 30'd83443;    5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;    5'd16: r = 30'd10430;    5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;     5'd19: r = 30'd1304;     5'd20: r = 30'd652;
      5'd21: r = 30'd326;      5'd22: r = 30'd163;      default: r = 30'd81;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/rix_cell.sv @@
// one cordic micro-rotation cell with its side data
`default_nettype none
module rix_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          vin,
  input  wire rix_pkg::vec_t din,
  input  wire rix_pkg::side_t sin,
  output logic               vout,
  output rix_pkg::vec_t      dout,
  output rix_pkg::side_t     sout
);
  logic signed [rix_pkg::VW-1:0] dx, dy;
  logic signed [33:0] a;
  rix_pkg::vec_t nxt;

  assign dx = din.y >>> STEP;
  assign dy = din.x >>> STEP;
  assign a = $signed({4'd0, rix_pkg::turn_atan(5'(STEP))});

  always_comb begin
    if (!din.z[33]) begin
      nxt.x = din.x - dx;
      nxt.y = din.y + dy;
      nxt.z = din.z - a;
    end else begin
      nxt.x = din.x + dx;
      nxt.y = din.y - dy;
      nxt.z = din.z + a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      dout <= nxt;
      sout <= sin;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/rix_chain.sv @@
// quadrant fold and a row of cordic cells
`default_nettype none
module rix_chain (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               vin,
  input  wire logic signed [43:0] xin,
  input  wire logic [31:0]        ang,
  input  wire rix_pkg::side_t     sin,
  output logic                    vout,
  output logic signed [43:0]      xo,
  output logic signed [43:0]      yo,
  output rix_pkg::side_t          sout
);
  localparam int unsigned N = rix_pkg::ITER;
  logic            v [N+1];
  rix_pkg::vec_t   d [N+1];
  rix_pkg::side_t  s [N+1];
  logic fold;
  logic [31:0] a2;

  assign fold = ang[31] ^ ang[30];
  assign a2 = fold ? ang + 32'h8000_0000 : ang;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= vin;
    end
    if (en) begin
      d[0].x <= fold ? -xin : xin;
      d[0].y <= '0;
      d[0].z <= {{2{a2[31]}}, a2};
      s[0] <= sin;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    rix_cell #(.STEP(i)) u_cell (
      .clk(clk), .rst(rst), .en(en), .vin(v[i]), .din(d[i]), .sin(s[i]),
      .vout(v[i+1]), .dout(d[i+1]), .sout(s[i+1])
    );
  end

  assign vout = v[N];
  assign xo = d[N].x;
  assign yo = d[N].y;
  assign sout = s[N];
endmodule
`default_nettype wire

@@ rtl/core/range_image_to_xyz_points_unit.sv @@
// Range image pixel to point converter, top level.
// One pixel enters per cycle and one point leaves per cycle, unless the pipe
// holds. A pixel passes the front end, the altitude cordic row, scaling,
// the azimuth cordic row, scaling and the output register. The whole pipe
// advances together and holds when the output word is not taken.
`default_nettype none
`include "range_image_to_xyz_points_unit_macros.svh"
module range_image_to_xyz_points_unit #(
  parameter int unsigned BEAM_COUNT = 32,
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // pixel_row[7:0], pixel_col[18:8], range_mm[34:19], intensity_raw[50:35]
  input  wire logic [55:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // pos_x[24:0], pos_y[49:25], pos_z[74:50], intensity_out[90:75]
  output logic [95:0]      m_tdata,
  // point_valid
  output logic             m_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  localparam int unsigned LASTB = ((BEAM_COUNT < rix_pkg::ROM_DEPTH) ?
                                   BEAM_COUNT : rix_pkg::ROM_DEPTH) - 1;
  localparam logic [7:0]  ROWMAX = 8'((MAX_ROWS > 256 ? 256 : MAX_ROWS) - 1);
  localparam logic [10:0] COLMAX = 11'((MAX_COLS > 2048 ? 2048 : MAX_COLS) - 1);

  logic [23:0] az_step;
  logic [20:0] alt_step;
  logic        int_fmt;
  logic        en;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      az_step <= 24'd16384;
      alt_step <= 21'd15997;
      int_fmt <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rix_pkg::REG_AZ:  az_step <= cfg_data;
        rix_pkg::REG_ALT: alt_step <= cfg_data[20:0];
        rix_pkg::REG_INT: int_fmt <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic ovalid;
  assign en = !ovalid || m_tready;
  assign s_tready = en;

  logic [7:0] row_in;
  logic [10:0] col_in;
  logic [15:0] rng_in, int_in;
  assign row_in = (s_tdata[7:0] > ROWMAX) ? ROWMAX : s_tdata[7:0];
  assign col_in = (s_tdata[18:8] > COLMAX) ? COLMAX : s_tdata[18:8];
  assign rng_in = s_tdata[34:19];
  assign int_in = s_tdata[50:35];

  // corrected range in 1/256 mm
  logic signed [25:0] roff;
  assign roff = $signed({2'b0, rng_in, 8'd0}) - rix_pkg::RANGE_OFFSET;

  // stage 1: beam position and azimuth product
  logic        v1;
  logic [28:0] pos1;
  logic [23:0] azp1;
  logic signed [43:0] r1;
  rix_pkg::side_t s1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
    if (en) begin
      pos1 <= row_in * alt_step;
      azp1 <= 24'(col_in * az_step);
      r1 <= {{10{roff[25]}}, roff, 8'd0};
      s1.valid <= rng_in != 16'd0;
      s1.inten <= int_fmt ? int_in : {int_in[7:0], 8'd0};
      s1.az <= '0;
    end
  end

  // stage 2: rom interpolation
  logic [12:0] lower;
  logic [4:0]  lo5, hi5;
  logic sat;
  assign lower = pos1[28:16];
  assign sat = lower >= 13'(LASTB);
  assign lo5 = sat ? 5'(LASTB) : lower[4:0];
  assign hi5 = sat ? 5'(LASTB) : lower[4:0] + 5'd1;
  logic v2;
  logic signed [34:0] alt2;
  logic signed [43:0] r2;
  rix_pkg::side_t s2;
  logic signed [15:0] a0;
  logic signed [16:0] da;
  assign a0 = rix_pkg::beam_rom(lo5);
  assign da = rix_pkg::beam_rom(hi5) - a0;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      alt2 <= sat ? 35'(a0 * 65536)
                  : 35'(a0 * 65536) + 35'(da) * 35'($signed({1'b0, pos1[15:0]}));
      r2 <= r1;
      s2.valid <= s1.valid;
      s2.inten <= s1.inten;
      s2.az <= 24'(24'd0 - azp1);
    end
  end

  // stage 3: radians to turns
  logic v3;
  logic [31:0] altt3;
  logic signed [43:0] r3;
  rix_pkg::side_t s3;
  logic signed [67:0] prod3;
  assign prod3 = alt2 * $signed({1'b0, rix_pkg::INV_PI});
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      altt3 <= 32'((prod3 + 68'sd2147483648) >>> 32);
      r3 <= r2;
      s3 <= s2;
    end
  end

  logic va;
  logic signed [43:0] xa, ya;
  rix_pkg::side_t sa;
  rix_chain u_alt (
    .clk(clk), .rst(rst), .en(en), .vin(v3), .xin(r3), .ang(altt3), .sin(s3),
    .vout(va), .xo(xa), .yo(ya), .sout(sa)
  );

  // gain correction of the altitude pass
  logic v4, v5;
  logic signed [67:0] cp4, sp4;
  logic signed [43:0] cc5;
  logic signed [24:0] z5;
  rix_pkg::side_t s4, s5;
  logic signed [67:0] sc_full;
  assign sc_full = (sp4 + 68'sd8388608) >>> 24;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= va;
      v5 <= v4;
    end
    if (en) begin
      cp4 <= xa * $signed({1'b0, rix_pkg::INV_GAIN});
      sp4 <= ya * $signed({1'b0, rix_pkg::INV_GAIN});
      s4 <= sa;
      cc5 <= 44'((cp4 + 68'sd8388608) >>> 24);
      z5 <= 25'((sc_full + 68'sd128) >>> 8);
      s5 <= s4;
    end
  end

  logic vb;
  logic signed [43:0] xb, yb;
  rix_pkg::side_t sb;
  rix_pkg::side_t s5z;
  logic signed [24:0] zq [rix_pkg::ITER+1];
  always_comb begin
    s5z = s5;
  end
  rix_chain u_az (
    .clk(clk), .rst(rst), .en(en), .vin(v5), .xin(cc5),
    .ang({s5.az, 8'd0}), .sin(s5z),
    .vout(vb), .xo(xb), .yo(yb), .sout(sb)
  );
  always_ff @(posedge clk) begin
    if (en) begin
      zq[0] <= z5;
      for (int i = 0; i < int'(rix_pkg::ITER); i++) zq[i+1] <= zq[i];
    end
  end

  // gain correction of the azimuth pass and output word
  logic v6;
  logic signed [67:0] xp6, yp6;
  logic signed [24:0] z6;
  rix_pkg::side_t s6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      ovalid <= 1'b0;
    end else if (en) begin
      v6 <= vb;
      ovalid <= v6;
    end
    if (en) begin
      xp6 <= xb * $signed({1'b0, rix_pkg::INV_GAIN});
      yp6 <= yb * $signed({1'b0, rix_pkg::INV_GAIN});
      z6 <= zq[rix_pkg::ITER];
      s6 <= sb;
      if (s6.valid) begin
        m_tdata <= {5'd0, s6.inten, z6,
                    25'((yp6 + 68'sd2147483648) >>> 32),
                    25'((xp6 + 68'sd2147483648) >>> 32)};
      end else begin
        m_tdata <= '0;
      end
      m_tuser <= s6.valid;
    end
  end
  assign m_tvalid = ovalid;

  `RIX_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata), "word changed while stalled")
  `RIX_ASSERT(a_inval, clk, rst, m_tvalid && !m_tuser |-> m_tdata == '0, "invalid point not zero")
  `RIX_ASSERT_R(a_rst, clk, $past(rst) |-> !m_tvalid, "output valid after reset")
endmodule
`default_nettype wire
